>>> hdl/cau_pkg.sv
// Shared types, operation codes and the saturation helper of the complex arithmetic unit.
package cau_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MAG = 3'd4;
    localparam logic [2:0] CMD_EQ  = 3'd5;

    localparam int Q_DEPTH = 4;

    localparam logic [64:0] POS_LIMIT = 65'h0_7FFF_FFFF;
    localparam logic [64:0] NEG_LIMIT = 65'h0_8000_0000;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MAG,
        OP_EQ,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_item;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // clamp a sign/magnitude value to the signed 32-bit range
    function automatic t_sat sat32(input logic neg, input logic [64:0] mag);
        t_sat r;
        if (!neg) begin
            if (mag > POS_LIMIT) begin
                r.val = 32'h7FFF_FFFF;
                r.sat = 1'b1;
            end else begin
                r.val = mag[31:0];
                r.sat = 1'b0;
            end
        end else if (mag > NEG_LIMIT) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = 32'(~mag[31:0] + 32'd1);
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/cau_front.sv
// Front end: decodes the operation of each word and queues it for the back end.
module cau_front import cau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_busy,
    output logic               o_valid,
    output t_item              o_item,
    input  logic               i_pop
);
    localparam int PW = $clog2(Q_DEPTH);

    t_item        r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    t_item        n_item;
    logic         push;
    logic         pop;

    // classify: magnitude reuses the product lanes, so feed a in place of b
    always_comb begin
        n_item.op   = OP_NONE;
        n_item.a_re = i_a_re;
        n_item.a_im = i_a_im;
        n_item.b_re = i_b_re;
        n_item.b_im = i_b_im;
        unique case (i_cmd)
            CMD_ADD: n_item.op = OP_ADD;
            CMD_SUB: n_item.op = OP_SUB;
            CMD_MUL: n_item.op = OP_MUL;
            CMD_DIV: n_item.op = OP_DIV;
            CMD_MAG: begin
                n_item.op   = OP_MAG;
                n_item.b_re = i_a_re;
                n_item.b_im = i_a_im;
            end
            CMD_EQ:  n_item.op = OP_EQ;
            default: n_item.op = OP_NONE;
        endcase
    end

    assign o_busy  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_start & ~o_busy;
    assign pop     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/cau_back.sv
// Back end: product, sum, pipelined divide and root stages, rounding and saturation.
module cau_back import cau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [31:0] o_res_re,
    output logic [31:0] o_res_im,
    output logic        o_is_equal,
    output logic        o_div_zero,
    output logic        o_saturated
);
    localparam int NQ       = 33 + FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam logic [64:0] HALF    = 65'(1) << (FRAC_BITS - 1);
    localparam logic [64:0] OVF_MAG = 65'h1_0000_0000;

    typedef struct packed {
        logic                 v;
        t_op                  op;
        logic                 dz;
        logic [1:0]           neg;
        logic [1:0]           ovf;
        logic [1:0][63:0]     rem;
        logic [1:0][NQ-1:0]   quo;
        logic [1:0][31:0]     dlow;
        logic [1:0][63:0]     mmag;
        logic [63:0]          den;
        logic [63:0]          sqx;
        logic [63:0]          sres;
        logic [31:0]          pre_re;
        logic [31:0]          pre_im;
        logic                 pre_eq;
        logic                 pre_sat;
    } t_stage;

    // stage 1: products and plain sums
    logic               r1_v;
    t_op                r1_op;
    logic signed [63:0] r1_p [6];
    logic signed [32:0] r1_sre;
    logic signed [32:0] r1_sim;
    logic               r1_eq;

    // stage 2: combined products
    logic               r2_v;
    t_op                r2_op;
    logic signed [64:0] r2_sx;
    logic signed [64:0] r2_sy;
    logic [63:0]        r2_den;
    logic [31:0]        r2_pre_re;
    logic [31:0]        r2_pre_im;
    logic               r2_pre_sat;
    logic               r2_eq;

    t_stage r_st [NQ+1];
    t_stage n_st [NQ+1];

    logic [32:0] mre;
    logic [32:0] mim;
    t_sat        s_re;
    t_sat        s_im;

    assign o_pop = i_valid;

    always_ff @(posedge i_clk) begin
        r1_v     <= i_rst_n & i_valid;
        r1_op    <= i_item.op;
        r1_p[0]  <= i_item.a_re * i_item.b_re;
        r1_p[1]  <= i_item.a_im * i_item.b_im;
        r1_p[2]  <= i_item.a_im * i_item.b_re;
        r1_p[3]  <= i_item.a_re * i_item.b_im;
        r1_p[4]  <= i_item.b_re * i_item.b_re;
        r1_p[5]  <= i_item.b_im * i_item.b_im;
        r1_sre   <= (i_item.op == OP_SUB) ? (33'(i_item.a_re) - 33'(i_item.b_re))
                                          : (33'(i_item.a_re) + 33'(i_item.b_re));
        r1_sim   <= (i_item.op == OP_SUB) ? (33'(i_item.a_im) - 33'(i_item.b_im))
                                          : (33'(i_item.a_im) + 33'(i_item.b_im));
        r1_eq    <= (i_item.a_re == i_item.b_re) && (i_item.a_im == i_item.b_im);
    end

    always_comb begin
        mre  = r1_sre[32] ? 33'(-r1_sre) : 33'(r1_sre);
        mim  = r1_sim[32] ? 33'(-r1_sim) : 33'(r1_sim);
        s_re = sat32(r1_sre[32], {32'd0, mre});
        s_im = sat32(r1_sim[32], {32'd0, mim});
    end

    always_ff @(posedge i_clk) begin
        r2_v       <= i_rst_n & r1_v;
        r2_op      <= r1_op;
        r2_sx      <= (r1_op == OP_MUL) ? (65'(r1_p[0]) - 65'(r1_p[1]))
                                        : (65'(r1_p[0]) + 65'(r1_p[1]));
        r2_sy      <= (r1_op == OP_MUL) ? (65'(r1_p[2]) + 65'(r1_p[3]))
                                        : (65'(r1_p[2]) - 65'(r1_p[3]));
        r2_den     <= 64'(r1_p[4]) + 64'(r1_p[5]);
        r2_pre_re  <= s_re.val;
        r2_pre_im  <= s_im.val;
        r2_pre_sat <= s_re.sat | s_im.sat;
        r2_eq      <= r1_eq;
    end

    // load divide/root pipe; per stage a quotient bit, and a root step if j < SQ_STEPS
    always_comb begin
        logic signed [64:0] s_ln;
        logic [63:0]        mag_ln;
        logic [64:0]        t_try;
        logic               ge;
        logic [63:0]        bitv;
        logic [63:0]        trial;

        n_st[0]         = '0;
        n_st[0].v       = r2_v;
        n_st[0].op      = r2_op;
        n_st[0].den     = r2_den;
        n_st[0].dz      = (r2_den == 64'd0);
        n_st[0].pre_re  = r2_pre_re;
        n_st[0].pre_im  = r2_pre_im;
        n_st[0].pre_sat = r2_pre_sat;
        n_st[0].pre_eq  = r2_eq;
        for (int l = 0; l < 2; l++) begin
            s_ln   = (l == 0) ? r2_sx : r2_sy;
            mag_ln = s_ln[64] ? 64'(-s_ln) : s_ln[63:0];
            n_st[0].neg[l]  = s_ln[64];
            n_st[0].rem[l]  = {32'd0, mag_ln[63:32]};
            n_st[0].ovf[l]  = ({32'd0, mag_ln[63:32]} >= r2_den);
            n_st[0].dlow[l] = mag_ln[31:0];
            n_st[0].mmag[l] = mag_ln;
        end
        n_st[0].sqx = n_st[0].mmag[0];

        for (int j = 0; j < NQ; j++) begin
            n_st[j+1] = r_st[j];
            for (int l = 0; l < 2; l++) begin
                t_try = {r_st[j].rem[l], r_st[j].dlow[l][31]};
                ge    = (t_try >= {1'b0, r_st[j].den});
                n_st[j+1].rem[l]  = ge ? 64'(t_try - {1'b0, r_st[j].den}) : t_try[63:0];
                n_st[j+1].quo[l]  = {r_st[j].quo[l][NQ-2:0], ge};
                n_st[j+1].dlow[l] = {r_st[j].dlow[l][30:0], 1'b0};
            end
            if (j < SQ_STEPS) begin
                bitv  = 64'(1) << 6'(2 * (SQ_STEPS - 1 - j));
                trial = r_st[j].sres + bitv;
                if (r_st[j].sqx >= trial) begin
                    n_st[j+1].sqx  = r_st[j].sqx - trial;
                    n_st[j+1].sres = (r_st[j].sres >> 1) + bitv;
                end else begin
                    n_st[j+1].sres = r_st[j].sres >> 1;
                end
            end else if (j == SQ_STEPS) begin
                // round the root to nearest
                if (r_st[j].sqx > r_st[j].sres) begin
                    n_st[j+1].sres = r_st[j].sres + 64'd1;
                end
            end
        end

        // drop every word in flight while reset is held
        if (!i_rst_n) begin
            for (int j = 0; j <= NQ; j++) begin
                n_st[j].v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= NQ; j++) begin
            r_st[j] <= n_st[j];
        end
    end

    // final rounding, saturation and result selection
    logic [64:0] base [2];
    logic [64:0] shv  [2];
    t_sat        ls   [2];
    logic [31:0] n_re;
    logic [31:0] n_im;
    logic        n_eq;
    logic        n_dz;
    logic        n_sat;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            unique case (r_st[NQ].op)
                OP_DIV: begin
                    base[l] = 65'(r_st[NQ].quo[l]) + 65'd1;
                    shv[l]  = r_st[NQ].ovf[l] ? OVF_MAG : (base[l] >> 1);
                end
                OP_MUL: begin
                    base[l] = 65'(r_st[NQ].mmag[l]) + HALF;
                    shv[l]  = base[l] >> FRAC_BITS;
                end
                default: begin
                    base[l] = 65'(r_st[NQ].sres);
                    shv[l]  = base[l];
                end
            endcase
            ls[l] = sat32(r_st[NQ].neg[l], shv[l]);
        end

        n_re  = '0;
        n_im  = '0;
        n_eq  = 1'b0;
        n_dz  = 1'b0;
        n_sat = 1'b0;
        unique case (r_st[NQ].op)
            OP_ADD, OP_SUB: begin
                n_re  = r_st[NQ].pre_re;
                n_im  = r_st[NQ].pre_im;
                n_sat = r_st[NQ].pre_sat;
            end
            OP_MUL: begin
                n_re  = ls[0].val;
                n_im  = ls[1].val;
                n_sat = ls[0].sat | ls[1].sat;
            end
            OP_DIV: begin
                if (r_st[NQ].dz) begin
                    n_dz = 1'b1;
                end else begin
                    n_re  = ls[0].val;
                    n_im  = ls[1].val;
                    n_sat = ls[0].sat | ls[1].sat;
                end
            end
            OP_MAG: begin
                n_re  = ls[0].val;
                n_sat = ls[0].sat;
            end
            OP_EQ:   n_eq = r_st[NQ].pre_eq;
            default: n_re = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_strobe    <= i_rst_n & r_st[NQ].v;
        o_res_re    <= n_re;
        o_res_im    <= n_im;
        o_is_equal  <= n_eq;
        o_div_zero  <= n_dz;
        o_saturated <= n_sat;
    end

endmodule

>>> hdl/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: front end, word queue and back end.
//
// Complex ALU on signed fixed point words with FRAC_BITS fraction bits (Q16.16 by
// default): add, subtract, multiply, divide, magnitude of a, and exact equality.
// A word is taken at each rising edge where start is high and busy is low; one
// word can be taken every clock cycle. Every word produces exactly one result,
// shown for a single cycle with o_strobe high, in the order the words came in.
// Each word passes the queue, the product and sum stages, the divide pipeline,
// which resolves one quotient bit per stage over FRAC_BITS + 33 stages, and the
// output register; the square root runs alongside in the first 32 divide stages.
// The receiver cannot stall: capture each result in the cycle its strobe is
// high. The front end queues decoded words and the back end drains one every
// cycle, so busy only rises if that queue fills. Undefined opcodes return an
// all-zero result; divide by zero returns zero with o_div_zero set.
module complex_arith_unit_top import cau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_strobe,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_is_equal,
    output logic               o_div_zero,
    output logic               o_saturated
);
    // queue hand-off between front and back
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    // decode and hold words until the back end takes them
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_busy  (busy),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // advance one word per cycle through the arithmetic pipeline
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_res_re    (o_res_re),
        .o_res_im    (o_res_im),
        .o_is_equal  (o_is_equal),
        .o_div_zero  (o_div_zero),
        .o_saturated (o_saturated)
    );

endmodule
